// ----- design/pfd_pkg.sv -----
// shared constants, types and codes of the trial division prime factorizer
package pfd_pkg;

	// fixed port widths
	localparam int VALUE_PORT_W = 16;
	localparam int FACTOR_W     = 10;
	localparam int INDEX_W      = 4;
	localparam int STATUS_W     = 2;

	// sieve and value sizing
	localparam int SIEVE_LIMIT  = 1024;
	localparam int VALUE_BITS   = 16;
	localparam int PRIME_BITS   = $clog2(SIEVE_LIMIT);
	// number of primes below the sieve limit
	localparam int PRIME_DEPTH  = 172;
	localparam int PRIME_AW     = $clog2(PRIME_DEPTH);
	localparam int PCNT_BITS    = $clog2(PRIME_DEPTH + 1);
	localparam int MAX_RESULTS  = 16;
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BEYOND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MARK,
		S_IDLE,
		S_FETCH,
		S_LOAD,
		S_DIV,
		S_EMIT
	} fsm_state_t;

	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] quot;
		logic [PRIME_BITS-1:0] rem;
	} div_res_t;

endpackage

// ----- design/prime_factorizer_trial_division.sv -----
// top level of the trial division prime factorizer with sieve-built prime table
//
// Splits each 16-bit unsigned item into its prime factors in ascending order,
// with repeats, one result per factor, the final result flagged by last.
// A value of 0 or 1 gives one result with status empty; a remaining factor
// that has no divisor among the primes below 1024 ends the list with a
// status beyond result (factor 0). After reset the block builds its prime
// table: a clearing pass over the 1024-entry mark memory, then a sieve of
// Eratosthenes (a read and a check per candidate, then the marking of the
// multiples of each new prime), during which item_stall stays high.
// Afterwards one item is worked at a time: every prime tried takes a table
// read, a divider load, 16 steps of the shared serial divider and a decision,
// and each factor found is handed to the output register before the same
// prime is tried again. The worst case, a value whose last factor lies
// beyond the table, tries all 172 primes. The serial divider works one
// quotient bit per cycle. The output register lets the sequencer go on
// while a result waits, until the next result is due.
module prime_factorizer_trial_division (
	input  logic                             clk,
	input  logic                             arst_n,
	// item channel
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic [pfd_pkg::VALUE_PORT_W-1:0] value,
	// result channel
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [pfd_pkg::FACTOR_W-1:0]     factor,
	output logic [pfd_pkg::INDEX_W-1:0]      factor_index,
	output logic                             last,
	output logic [pfd_pkg::STATUS_W-1:0]     status
);
	import pfd_pkg::*;

	// control state
	fsm_state_t           state_q, state_d;
	logic [PCNT_BITS-1:0] pcnt_q, pcnt_d;      // primes in the table
	logic                 out_valid_q, out_valid_d;

	// datapath registers
	logic [PRIME_BITS-1:0]   i_q, i_d;         // clear address, then sieve candidate
	logic [PRIME_BITS:0]     m_q, m_d;         // multiple being marked
	logic [VALUE_BITS-1:0]   n_q, n_d;         // remaining value
	logic [PCNT_BITS-1:0]    j_q, j_d;         // prime being tried
	logic [PRIME_BITS-1:0]   p_q, p_d;
	logic [INDEX_W-1:0]      k_q, k_d;         // results given so far
	logic [PRIME_BITS-1:0]   pend_factor_q, pend_factor_d;
	logic                    pend_last_q, pend_last_d;
	status_t                 pend_status_q, pend_status_d;
	logic [FACTOR_W-1:0]     factor_q, factor_d;
	logic [INDEX_W-1:0]      index_q, index_d;
	logic                    last_q, last_d;
	status_t                 status_q, status_d;

	// memories and divider hookup
	logic                  mark_we, mark_wdata, mark_rdata;
	logic [PRIME_BITS-1:0] mark_waddr;
	logic                  prime_we;
	logic [PRIME_BITS-1:0] prime_rdata;
	logic                  div_start;
	div_res_t              div_res;

	// helpers
	logic                    slot_free;
	logic [2*PRIME_BITS-1:0] square;
	logic [PRIME_BITS:0]     m_next;
	logic                    last_cand;
	logic [VALUE_BITS-1:0]   in_n;

	assign slot_free = !out_valid_q || !result_stall;
	assign square    = {{PRIME_BITS{1'b0}}, i_q} * {{PRIME_BITS{1'b0}}, i_q};
	assign m_next    = m_q + {1'b0, i_q};
	assign last_cand = i_q == PRIME_BITS'(SIEVE_LIMIT - 1);
	assign in_n      = VALUE_BITS'(value);

	pfd_ram #(
		.WIDTH(1),
		.DEPTH(SIEVE_LIMIT)
	) u_marks (
		.clk  (clk),
		.we   (mark_we),
		.waddr(mark_waddr),
		.wdata(mark_wdata),
		.raddr(i_q),
		.rdata(mark_rdata)
	);

	pfd_ram #(
		.WIDTH(PRIME_BITS),
		.DEPTH(PRIME_DEPTH)
	) u_primes (
		.clk  (clk),
		.we   (prime_we),
		.waddr(pcnt_q[PRIME_AW-1:0]),
		.wdata(i_q),
		.raddr(j_q[PRIME_AW-1:0]),
		.rdata(prime_rdata)
	);

	pfd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(n_q),
		.divisor (prime_rdata),
		.res     (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
		end else begin
			state_q     <= state_d;
			pcnt_q      <= pcnt_d;
			out_valid_q <= out_valid_d;
			i_q         <= i_d;
		end
	end

	always_ff @(posedge clk) begin
		m_q           <= m_d;
		n_q           <= n_d;
		j_q           <= j_d;
		p_q           <= p_d;
		k_q           <= k_d;
		pend_factor_q <= pend_factor_d;
		pend_last_q   <= pend_last_d;
		pend_status_q <= pend_status_d;
		factor_q      <= factor_d;
		index_q       <= index_d;
		last_q        <= last_d;
		status_q      <= status_d;
	end

	always_comb begin
		state_d       = state_q;
		pcnt_d        = pcnt_q;
		i_d           = i_q;
		m_d           = m_q;
		n_d           = n_q;
		j_d           = j_q;
		p_d           = p_q;
		k_d           = k_q;
		pend_factor_d = pend_factor_q;
		pend_last_d   = pend_last_q;
		pend_status_d = pend_status_q;
		factor_d      = factor_q;
		index_d       = index_q;
		last_d        = last_q;
		status_d      = status_q;
		out_valid_d   = out_valid_q && result_stall;
		mark_we       = 1'b0;
		mark_waddr    = i_q;
		mark_wdata    = 1'b0;
		prime_we      = 1'b0;
		div_start     = 1'b0;
		item_stall    = 1'b1;

		unique case (state_q)
			// wipe the mark memory
			S_CLEAR: begin
				mark_we = 1'b1;
				if (last_cand) begin
					i_d     = PRIME_BITS'(2);
					state_d = S_SCAN_RD;
				end else begin
					i_d = i_q + 1'b1;
				end
			end
			// mark of the candidate is read here, seen next cycle
			S_SCAN_RD: begin
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (!mark_rdata) begin
					prime_we = 1'b1;
					pcnt_d   = pcnt_q + 1'b1;
				end
				if (!mark_rdata && square < (2*PRIME_BITS)'(SIEVE_LIMIT)) begin
					m_d     = (PRIME_BITS + 1)'(square);
					state_d = S_MARK;
				end else if (last_cand) begin
					state_d = S_IDLE;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			// cross out the multiples of the new prime
			S_MARK: begin
				mark_we    = 1'b1;
				mark_waddr = m_q[PRIME_BITS-1:0];
				mark_wdata = 1'b1;
				m_d        = m_next;
				if (m_next >= (PRIME_BITS + 1)'(SIEVE_LIMIT)) begin
					if (last_cand) begin
						state_d = S_IDLE;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = S_SCAN_RD;
					end
				end
			end
			S_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					n_d = in_n;
					j_d = '0;
					k_d = '0;
					if (in_n < VALUE_BITS'(2)) begin
						pend_factor_d = '0;
						pend_last_d   = 1'b1;
						pend_status_d = ST_EMPTY;
						state_d       = S_EMIT;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			// table read of the current prime, or the table ran out
			S_FETCH: begin
				if (j_q == pcnt_q) begin
					pend_factor_d = '0;
					pend_last_d   = 1'b1;
					pend_status_d = ST_BEYOND;
					state_d       = S_EMIT;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				p_d       = prime_rdata;
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				if (div_res.done) begin
					if (div_res.rem != '0) begin
						j_d     = j_q + 1'b1;
						state_d = S_FETCH;
					end else if (k_q == INDEX_W'(MAX_RESULTS - 1) &&
					             n_q != VALUE_BITS'(p_q)) begin
						// last slot and still not done
						pend_factor_d = '0;
						pend_last_d   = 1'b1;
						pend_status_d = ST_BEYOND;
						state_d       = S_EMIT;
					end else begin
						n_d           = div_res.quot;
						pend_factor_d = p_q;
						pend_last_d   = div_res.quot == VALUE_BITS'(1);
						pend_status_d = ST_OK;
						state_d       = S_EMIT;
					end
				end
			end
			// hand the result to the output register once it is free
			S_EMIT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					factor_d    = FACTOR_W'(pend_factor_q);
					index_d     = k_q;
					last_d      = pend_last_q;
					status_d    = pend_status_q;
					k_d         = k_q + 1'b1;
					state_d     = pend_last_q ? S_IDLE : S_FETCH;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign factor       = factor_q;
	assign factor_index = index_q;
	assign last         = last_q;
	assign status       = status_q;

	// a new result only comes out of the emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");

	// the divider only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider done outside wait state");

	// table never outgrows its memory
	assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCNT_BITS'(PRIME_DEPTH))
		else $error("prime count overflow");

	// an ok result always carries a real factor
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OK |-> factor_q > FACTOR_W'(1))
		else $error("ok result without factor");
endmodule

// ----- design/pfd_ram.sv -----
// generic simple dual port ram with registered read
module pfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/pfd_div.sv -----
// restoring serial divider, one quotient bit per cycle
module pfd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pfd_pkg::VALUE_BITS-1:0] dividend,
	input  logic [pfd_pkg::PRIME_BITS-1:0] divisor,
	output pfd_pkg::div_res_t              res
);
	import pfd_pkg::*;

	logic [PRIME_BITS-1:0]   rem_q;
	logic [VALUE_BITS-1:0]   quot_q;
	logic [PRIME_BITS-1:0]   dvs_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [PRIME_BITS:0]     shifted;
	logic                    fits;

	// shift in the next dividend bit and try the subtract
	assign shifted = {rem_q, quot_q[VALUE_BITS-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			// pulse right after the final quotient bit
			done_q <= !start && busy_q && cnt_q == '0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_BITS'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? PRIME_BITS'(shifted - {1'b0, dvs_q}) : shifted[PRIME_BITS-1:0];
			quot_q <= {quot_q[VALUE_BITS-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;
endmodule

// ----- tb/prime_factorizer_trial_division_tb.sv -----
// self-checking testbench for the trial division prime factorizer
module prime_factorizer_trial_division_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pfd_pkg::*;

	// receiver hold-off long enough for the block to back up into its input
	localparam int LONG_HOLD    = 1500;
	localparam int RANDOM_ITEMS = 200;
	// the tail of the random part runs with no idling on either side
	localparam int QUIET_TAIL   = 30;
	localparam int TAIL_CYCLES  = 300;

	// one factor result as it appears on the result channel
	typedef struct {
		logic [FACTOR_W-1:0] factor;
		logic [INDEX_W-1:0]  idx;
		logic                last;
		status_t             status;
	} factor_rec_t;

	// keeps its own prime table and the queue of factors still owed by the block
	class factor_board;
		int unsigned primes[$];
		factor_rec_t owed_factors[$];
		int          errors;

		function new();
			bit marks[SIEVE_LIMIT];
			errors = 0;
			for (int i = 2; i < SIEVE_LIMIT; i++) begin
				if (marks[i])
					continue;
				primes.push_back(i);
				for (int m = i * i; m < SIEVE_LIMIT; m += i)
					marks[m] = 1'b1;
			end
		endfunction

		function void owe(int unsigned f, int k, bit l, status_t s);
			factor_rec_t r;
			r.factor = f[FACTOR_W-1:0];
			r.idx    = k[INDEX_W-1:0];
			r.last   = l;
			r.status = s;
			owed_factors.push_back(r);
		endfunction

		// factor an accepted item and queue the results it must produce
		function void note_value(logic [VALUE_PORT_W-1:0] v);
			int unsigned n;
			int unsigned p;
			int          j;
			int          k;
			n = v & ((1 << VALUE_BITS) - 1);
			j = 0;
			k = 0;
			if (n < 2) begin
				owe(0, 0, 1'b1, ST_EMPTY);
				return;
			end
			while (n > 1) begin
				// remaining value has no divisor left in the table
				if (j >= primes.size()) begin
					owe(0, k, 1'b1, ST_BEYOND);
					return;
				end
				p = primes[j];
				if (n % p != 0) begin
					j++;
					continue;
				end
				// last slot cannot hold a factor that leaves more to do
				if (k == MAX_RESULTS - 1 && n != p) begin
					owe(0, k, 1'b1, ST_BEYOND);
					return;
				end
				n = n / p;
				owe(p, k, n == 1, ST_OK);
				k++;
			end
		endfunction

		function void report(string field, int unsigned want, logic [31:0] got);
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		endfunction

		// compare one accepted result against the oldest owed factor
		function void check_factor(factor_rec_t got);
			factor_rec_t want;
			if (owed_factors.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual factor %0d index %0d last %0d status %0d",
					$time, got.factor, got.idx, got.last, got.status);
				errors++;
				return;
			end
			want = owed_factors.pop_front();
			if (got.factor !== want.factor)
				report("factor", want.factor, got.factor);
			if (got.idx !== want.idx)
				report("factor_index", want.idx, got.idx);
			if (got.last !== want.last)
				report("last", want.last, got.last);
			if (got.status !== want.status)
				report("status", want.status, got.status);
		endfunction

		function int pending();
			return owed_factors.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    item_valid;
	logic                    item_stall;
	logic [VALUE_PORT_W-1:0] value;
	logic                    result_valid;
	logic                    result_stall;
	logic [FACTOR_W-1:0]     factor;
	logic [INDEX_W-1:0]      factor_index;
	logic                    last;
	logic [STATUS_W-1:0]     status;

	factor_board board = new();

	// handshake between the stimulus and the result-side idling process
	bit hold_req = 1'b0;
	bit quiet    = 1'b0;

	prime_factorizer_trial_division uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.value        (value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.factor       (factor),
		.factor_index (factor_index),
		.last         (last),
		.status       (status)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// offer one item from a falling edge and hold it until accepted;
	// valid stays high so the next call can follow back to back
	task automatic send_value(input logic [VALUE_PORT_W-1:0] v);
		item_valid = 1'b1;
		value      = v;
		do
			@(posedge clk);
		while (item_stall);
		board.note_value(v);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int cycles);
		item_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// product of table primes below 2^16; small primes most of the time
	function automatic logic [VALUE_PORT_W-1:0] smooth_value(input int top_idx);
		int unsigned v;
		int unsigned p;
		v = 1;
		repeat ($urandom_range(1, 15)) begin
			p = board.primes[$urandom_range(0, top_idx)];
			if (v * p <= 65535)
				v = v * p;
		end
		return v[VALUE_PORT_W-1:0];
	endfunction

	function automatic logic [VALUE_PORT_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return VALUE_PORT_W'($urandom_range(0, 65535));
			4, 5:       return smooth_value(10);
			6:          return smooth_value(board.primes.size() - 1);
			// odd values well above the table, often with a factor beyond it
			7:          return VALUE_PORT_W'($urandom_range(1024, 65535) | 1);
			8:          return VALUE_PORT_W'($urandom_range(0, 3));
			default:    return VALUE_PORT_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
		endcase
	endfunction

	// result side: random stall bursts, calm stretches, and the long hold-off
	initial begin
		int stall_left;
		int calm_left;
		bit calm;
		stall_left   = 0;
		calm_left    = 0;
		calm         = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (calm_left == 0) begin
				calm      = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(100, 400);
			end
			calm_left--;
			if (stall_left == 0 && !quiet && !calm && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 14);
			if (stall_left > 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	// result monitor, sampling at the rising edge
	always @(posedge clk) begin
		factor_rec_t got;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			got.factor = factor;
			got.idx    = factor_index;
			got.last   = last;
			got.status = status_t'(status);
			board.check_factor(got);
		end
	end

	// overall limit, several times the slowest legal run
	initial begin
		#60_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [VALUE_PORT_W-1:0] directed[$];
		bit tx_calm;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		value      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty values, smallest primes, top of the range, many repeats,
		// largest table prime, factors beyond the table alone and after ok factors
		directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd49, 16'd65535, 16'd65534,
			16'd65521, 16'd32768, 16'd1021, 16'd1031, 16'd2062, 16'd65344, 16'd62281,
			16'd59049, 16'd21845, 16'd43690, 16'd65498, 16'd1022, 16'd1024, 16'd30030,
			16'd65472};
		foreach (directed[i])
			send_value(directed[i]);

		// sender pause until everything owed has come back
		item_valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		// long receiver hold-off while quick items keep coming, so the block backs up
		hold_req = 1'b1;
		repeat (8)
			send_value(smooth_value(5));

		tx_calm = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if (i % 20 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			send_value(random_value());
			if (!quiet && !tx_calm && $urandom_range(0, 2) == 0)
				idle_sender($urandom_range(1, 14));
		end
		item_valid = 1'b0;

		// drain, then watch a little longer for anything extra
		while (board.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
